/* src/kac_pkg.sv */
// ----------------------------------------------------------------------------
// kac_pkg: shared types, constants and helpers for the anomaly converter
// Fixed-point widths, CORDIC arctangent table, angle wrap and command struct.
// ----------------------------------------------------------------------------
package kac_pkg;

	localparam int ANGLE_W  = 32;  // signed Q3.29 radians
	localparam int ECC_W    = 31;  // unsigned Q.31 eccentricity
	localparam int CORDIC_W = 36;  // CORDIC x / y datapath
	localparam int CZ_W     = 35;  // CORDIC angle accumulator
	localparam int WRAP_W   = 36;  // width of values handed to the wrap
	localparam int STEPS    = 30;  // CORDIC micro-rotations
	localparam int ITER_W   = 7;
	localparam int TOL_W    = 21;
	localparam int DVD_W    = 63;  // |f| * 2^30
	localparam int DVS_W    = 33;  // Newton derivative, Q.30

	localparam logic signed [WRAP_W-1:0] PI_Q29      = 36'sd1686629713;
	localparam logic signed [WRAP_W-1:0] HALF_PI_Q29 = 36'sd843314857;
	localparam logic signed [WRAP_W-1:0] TWO_PI_Q29  = 36'sd3373259426;
	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 36'sd652032874;

	typedef struct packed {
		logic start;
		logic vector;  // 1: vectoring (atan2), 0: rotation (sin / cos)
	} cordic_cmd_t;

	// Fold a value within [-3*pi, 3*pi] into [-pi, pi].
	function automatic logic signed [ANGLE_W-1:0] wrap_angle(input logic signed [WRAP_W-1:0] a);
		logic signed [WRAP_W-1:0] r;
		r = a;
		if (a > PI_Q29) begin
			r = a - TWO_PI_Q29;
		end else if (a < -PI_Q29) begin
			r = a + TWO_PI_Q29;
		end
		return r[ANGLE_W-1:0];
	endfunction

	function automatic logic signed [CZ_W-1:0] atan_q29(input logic [4:0] i);
		logic signed [CZ_W-1:0] r;
		case (i)
			5'd0: r = 35'sd421657428;
			5'd1: r = 35'sd248918915;
			5'd2: r = 35'sd131521918;
			5'd3: r = 35'sd66762579;
			5'd4: r = 35'sd33510843;
			5'd5: r = 35'sd16771758;
			5'd6: r = 35'sd8387925;
			5'd7: r = 35'sd4194219;
			5'd8: r = 35'sd2097141;
			5'd9: r = 35'sd1048575;
			default: r = 35'sd1 <<< (5'd29 - i);
		endcase
		return r;
	endfunction

endpackage

/* src/kac_cordic.sv */
// ----------------------------------------------------------------------------
// kac_cordic: shared iterative CORDIC
// One micro-rotation per cycle; rotation mode gives sine / cosine, vectoring
// mode gives the wrapped atan2 angle.
// ----------------------------------------------------------------------------
module kac_cordic import kac_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cordic_cmd_t                cmd,
	input  logic signed [CORDIC_W-1:0] x_in,
	input  logic signed [CORDIC_W-1:0] y_in,
	input  logic signed [ANGLE_W-1:0]  z_in,
	output logic                       done,
	output logic signed [CORDIC_W-1:0] sin_out,
	output logic signed [CORDIC_W-1:0] cos_out,
	output logic signed [ANGLE_W-1:0]  angle_out
);

	logic signed [CORDIC_W-1:0] x_q, y_q, xs, ys;
	logic signed [CZ_W-1:0]     z_q, at;
	logic [4:0]                 step_q;
	logic                       busy_q, done_q, vec_q, flip_q, zero_q, rot_dir;
	logic signed [WRAP_W-1:0]   z_ext, z_acc;

	assign xs      = x_q >>> step_q;
	assign ys      = y_q >>> step_q;
	assign at      = atan_q29(step_q);
	assign rot_dir = vec_q ? y_q[CORDIC_W-1] : !z_q[CZ_W-1];
	assign z_ext   = {{(WRAP_W-ANGLE_W){z_in[ANGLE_W-1]}}, z_in};
	assign z_acc   = {{(WRAP_W-CZ_W){z_q[CZ_W-1]}}, z_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == 5'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			step_q <= '0;
			vec_q  <= cmd.vector;
			flip_q <= 1'b0;
			zero_q <= (x_in == '0) && (y_in == '0);
			if (cmd.vector) begin
				// pre-rotate the left half plane by a quarter turn
				if (x_in < 0) begin
					if (y_in >= 0) begin
						x_q <= y_in;
						y_q <= -x_in;
						z_q <= HALF_PI_Q29[CZ_W-1:0];
					end else begin
						x_q <= -y_in;
						y_q <= x_in;
						z_q <= -HALF_PI_Q29[CZ_W-1:0];
					end
				end else begin
					x_q <= x_in;
					y_q <= y_in;
					z_q <= '0;
				end
			end else begin
				x_q <= CORDIC_GAIN;
				y_q <= '0;
				// fold into [-pi/2, pi/2] and flip the signs afterwards
				if (z_ext > HALF_PI_Q29) begin
					z_q    <= CZ_W'(z_ext - PI_Q29);
					flip_q <= 1'b1;
				end else if (z_ext < -HALF_PI_Q29) begin
					z_q    <= CZ_W'(z_ext + PI_Q29);
					flip_q <= 1'b1;
				end else begin
					z_q <= CZ_W'(z_ext);
				end
			end
		end else if (busy_q) begin
			step_q <= step_q + 5'd1;
			if (rot_dir) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign done      = done_q;
	assign sin_out   = flip_q ? -y_q : y_q;
	assign cos_out   = flip_q ? -x_q : x_q;
	assign angle_out = zero_q ? '0 : wrap_angle(z_acc);

endmodule

/* src/kac_div.sv */
// ----------------------------------------------------------------------------
// kac_div: restoring unsigned divider
// One quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module kac_div import kac_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic             busy_q, done_q, ge;
	logic [5:0]       cnt_q;
	logic [DVD_W-1:0] dq_q;
	logic [DVS_W-1:0] rem_q, dvs_q;
	logic [DVS_W:0]   rem_sh, rem_d;

	assign rem_sh = {rem_q, dq_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign rem_d  = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 6'(DVD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cnt_q <= '0;
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
			rem_q <= rem_d[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

/* src/kepler_anomaly_converter_unit.sv */
// ----------------------------------------------------------------------------
// kepler_anomaly_converter_unit: mean / eccentric / true anomaly converter
// Newton solver for Kepler's equation plus closed-form conversions.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one transaction per request. tuser selects the
//   conversion, tdata carries the source angle and the eccentricity.
//   Output stream (m_axis_*): one transaction per request with the wrapped
//   angle and the Newton step count; tuser flags convergence.
//   Configuration channel (cfg_*): index 0 writes the step tolerance, index
//   1 the iteration limit; write only while the unit is idle.
// Timing:
//   One request is in flight at a time; s_axis_tready is high only while the
//   sequencer idles. Each sine / cosine or atan2 runs on the shared CORDIC,
//   the square root of 1-e^2 on a bit-pair iteration, each Newton quotient on
//   the serial divider. Kepler's equation takes up to (limit + 2) Newton
//   steps, plus the closed-form tail for mean to true.
// Reset and stalls:
//   Reset clears the sequencer and the output register and restores the
//   tolerance (1) and the limit (100). A finished result sits in the output
//   register until taken; the next request may be accepted meanwhile, and
//   its result waits in the sequencer while the receiver stalls.
module kepler_anomaly_converter_unit import kac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] angle_in, [62:32] eccentricity, [63] zero
	input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [31:0] angle_out, [38:32] iterations_used, [39] zero
	output logic        m_axis_tuser,   // [0] converged
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [20:0] cfg_data
);

	localparam logic [2:0] REQ_M2E = 3'd0, REQ_E2T = 3'd1, REQ_M2T = 3'd2,
	                       REQ_T2E = 3'd3, REQ_E2M = 3'd4, REQ_T2M = 3'd5;
	localparam logic [1:0] OP_NEWTON = 2'd0, OP_E2T = 2'd1, OP_T2E = 2'd2, OP_E2M = 2'd3;
	localparam logic [0:0] REG_TOL = 1'd0, REG_LIM = 1'd1;
	localparam logic [ITER_W-1:0] MAX_LIMIT = 7'd100;

	localparam logic [3:0] S_IDLE = 4'd0, S_ESQ = 4'd1, S_SQINIT = 4'd2, S_SQRT = 4'd3,
	                       S_OPSTART = 4'd4, S_SC_WAIT = 4'd5, S_MUL_S = 4'd6,
	                       S_E2M_FIN = 4'd7, S_VEC = 4'd8, S_ATAN_WAIT = 4'd9,
	                       S_MUL_C = 4'd10, S_DIVSTART = 4'd11, S_DIV_WAIT = 4'd12,
	                       S_NEWT_CHK = 4'd13, S_OUT = 4'd14;

	logic [3:0]                 state_q;
	logic [TOL_W-1:0]           tol_q;
	logic [ITER_W-1:0]          lim_q, lim_eff, n_q;
	logic [ECC_W-1:0]           e_q;
	logic signed [ANGLE_W-1:0]  ang_q, mw_q, ea_q, est_q, res_q;
	logic [1:0]                 op_q, op2_q;
	logic                       has2_q, conv_q;
	logic [31:0]                root_q;
	logic [62:0]                sq_v_q, sq_bit_q;
	logic [63:0]                sq_res_q, sq_trial, sq_res_d;
	logic                       sq_take;
	logic signed [CORDIC_W-1:0] s_q, c_q;
	logic signed [68:0]         prod_q, prod_d, p32, p31, p30;
	logic [31:0]                mul_a;
	logic signed [CORDIC_W-1:0] mul_b;
	logic signed [33:0]         f_q;
	logic [33:0]                f_mag;
	logic signed [WRAP_W-1:0]   f_d, fp_d, e2m_d, ea_w;
	logic [DVS_W-1:0]           fp_cl;
	logic signed [64:0]         q_s, diff_d;
	logic signed [ANGLE_W-1:0]  sat_d;
	logic signed [ANGLE_W:0]    step_d;
	logic [ANGLE_W:0]           step_mag;
	logic                       out_valid_q;
	logic [ANGLE_W-1:0]         out_angle_q;
	logic [ITER_W-1:0]          out_iter_q;
	logic                       out_conv_q;

	// angle input of the request, wrapped before any use
	logic signed [ANGLE_W-1:0]  a_in, a_wrap;
	logic [ECC_W-1:0]           e_in;

	cordic_cmd_t                c_cmd;
	logic signed [CORDIC_W-1:0] c_x, c_y, c_sin, c_cos;
	logic signed [ANGLE_W-1:0]  c_z, c_angle;
	logic                       c_done;
	logic                       d_start, d_done;
	logic [DVD_W-1:0]           d_quo;

	logic                       op_done;
	logic signed [ANGLE_W-1:0]  op_res;

	assign a_in   = $signed(s_axis_tdata[31:0]);
	assign e_in   = s_axis_tdata[62:32];
	assign a_wrap = wrap_angle({{(WRAP_W-ANGLE_W){a_in[ANGLE_W-1]}}, a_in});
	assign ea_w   = {{(WRAP_W-ANGLE_W){ea_q[ANGLE_W-1]}}, ea_q};

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign lim_eff       = (lim_q > MAX_LIMIT) ? MAX_LIMIT : lim_q;

	// --- shared multiplier: e*e, e*s, e*c and sqrt(1-e^2)*s ---------------
	always_comb begin
		mul_a = {1'b0, e_q};
		mul_b = s_q;
		case (state_q)
			S_ESQ: mul_b = $signed({5'b0, e_q});
			S_MUL_S: begin
				if (op_q == OP_E2T || op_q == OP_T2E) begin
					mul_a = root_q;
				end
			end
			S_MUL_C: mul_b = c_q;
			default: ;
		endcase
	end

	assign prod_d = $signed({1'b0, mul_a}) * mul_b;
	assign p32    = prod_q >>> 32;
	assign p31    = prod_q >>> 31;
	assign p30    = prod_q >>> 30;

	// --- bit-pair integer square root of 2^62 - e^2 -----------------------
	assign sq_trial = sq_res_q + {1'b0, sq_bit_q};
	assign sq_take  = {1'b0, sq_v_q} >= sq_trial;
	assign sq_res_d = sq_take ? (sq_res_q >> 1) + {1'b0, sq_bit_q} : sq_res_q >> 1;

	// --- Newton arithmetic ------------------------------------------------
	assign e2m_d = {{(WRAP_W-ANGLE_W){ang_q[ANGLE_W-1]}}, ang_q} - $signed(p32[WRAP_W-1:0]);
	assign f_d   = ea_w - $signed(p32[WRAP_W-1:0])
	             - {{(WRAP_W-ANGLE_W){mw_q[ANGLE_W-1]}}, mw_q};
	assign fp_d  = (WRAP_W'(36'sd1) <<< 30) - $signed(p31[WRAP_W-1:0]);
	assign fp_cl = (fp_d < 1) ? DVS_W'(1) : fp_d[DVS_W-1:0];
	assign f_mag = f_q[33] ? 34'(-f_q) : 34'(f_q);

	assign q_s    = f_q[33] ? -$signed({2'b0, d_quo}) : $signed({2'b0, d_quo});
	assign diff_d = {{(65-ANGLE_W){ea_q[ANGLE_W-1]}}, ea_q} - q_s;
	always_comb begin
		if (diff_d > 65'sd2147483647) begin
			sat_d = 32'sh7FFFFFFF;
		end else if (diff_d < -65'sd2147483648) begin
			sat_d = 32'sh80000000;
		end else begin
			sat_d = diff_d[ANGLE_W-1:0];
		end
	end

	assign step_d   = {est_q[ANGLE_W-1], est_q} - {ea_q[ANGLE_W-1], ea_q};
	assign step_mag = step_d[ANGLE_W] ? (ANGLE_W+1)'(-step_d) : (ANGLE_W+1)'(step_d);

	// --- shared units -----------------------------------------------------
	always_comb begin
		c_cmd.start  = 1'b0;
		c_cmd.vector = 1'b0;
		c_x = (c_q <<< 1) + $signed({5'b0, e_q});
		c_y = $signed(p30[CORDIC_W-1:0]);
		c_z = (op_q == OP_NEWTON) ? wrap_angle(ea_w) : ang_q;
		if (op_q == OP_E2T) begin
			c_x = (c_q <<< 1) - $signed({5'b0, e_q});
		end
		case (state_q)
			S_OPSTART: c_cmd.start = 1'b1;
			S_VEC: begin
				c_cmd.start  = 1'b1;
				c_cmd.vector = 1'b1;
			end
			default: ;
		endcase
	end

	kac_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (c_cmd),
		.x_in      (c_x),
		.y_in      (c_y),
		.z_in      (c_z),
		.done      (c_done),
		.sin_out   (c_sin),
		.cos_out   (c_cos),
		.angle_out (c_angle)
	);

	assign d_start = (state_q == S_DIVSTART);

	kac_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (d_start),
		.dividend ({f_mag[32:0], 30'b0}),
		.divisor  (fp_cl),
		.done     (d_done),
		.quotient (d_quo)
	);

	// --- end of one conversion step ---------------------------------------
	always_comb begin
		op_done = 1'b0;
		op_res  = wrap_angle(e2m_d);
		case (state_q)
			S_E2M_FIN: op_done = 1'b1;
			S_ATAN_WAIT: begin
				op_done = c_done;
				op_res  = c_angle;
			end
			S_NEWT_CHK: begin
				op_done = (step_mag < (ANGLE_W+1)'(tol_q)) || (n_q > lim_eff);
				op_res  = wrap_angle({{(WRAP_W-ANGLE_W){est_q[ANGLE_W-1]}}, est_q});
			end
			default: ;
		endcase
	end

	// --- configuration registers ------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_W'(1);
			lim_q <= MAX_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TOL: tol_q <= cfg_data;
				REG_LIM: lim_q <= cfg_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	// --- sequencer --------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						case (s_axis_tuser)
							REQ_E2T, REQ_M2T, REQ_T2E, REQ_T2M: state_q <= S_ESQ;
							REQ_M2E, REQ_E2M: state_q <= S_OPSTART;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_ESQ:     state_q <= S_SQINIT;
				S_SQINIT:  state_q <= S_SQRT;
				S_SQRT: begin
					if (sq_bit_q[0]) begin
						state_q <= S_OPSTART;
					end
				end
				S_OPSTART: state_q <= S_SC_WAIT;
				S_SC_WAIT: begin
					if (c_done) begin
						state_q <= S_MUL_S;
					end
				end
				S_MUL_S: begin
					case (op_q)
						OP_E2M:    state_q <= S_E2M_FIN;
						OP_NEWTON: state_q <= S_MUL_C;
						default:   state_q <= S_VEC;
					endcase
				end
				// chain into the second conversion or hand the angle to the output
				S_E2M_FIN:  state_q <= has2_q ? S_OPSTART : S_OUT;
				S_VEC:      state_q <= S_ATAN_WAIT;
				S_ATAN_WAIT: begin
					if (c_done) begin
						state_q <= has2_q ? S_OPSTART : S_OUT;
					end
				end
				S_MUL_C:    state_q <= S_DIVSTART;
				S_DIVSTART: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: begin
					if (d_done) begin
						state_q <= S_NEWT_CHK;
					end
				end
				S_NEWT_CHK: state_q <= (op_done && !has2_q) ? S_OUT : S_OPSTART;
				S_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// --- datapath registers -----------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				e_q    <= e_in;
				ang_q  <= a_wrap;
				mw_q   <= a_wrap;
				ea_q   <= a_wrap;
				res_q  <= a_wrap;
				n_q    <= '0;
				case (s_axis_tuser)
					REQ_M2E: begin
						op_q   <= OP_NEWTON;
						op2_q  <= OP_E2T;
						has2_q <= 1'b0;
						conv_q <= 1'b1;
					end
					REQ_E2T: begin
						op_q   <= OP_E2T;
						op2_q  <= OP_E2T;
						has2_q <= 1'b0;
						conv_q <= 1'b1;
					end
					REQ_M2T: begin
						op_q   <= OP_NEWTON;
						op2_q  <= OP_E2T;
						has2_q <= 1'b1;
						conv_q <= 1'b1;
					end
					REQ_T2E: begin
						op_q   <= OP_T2E;
						op2_q  <= OP_E2T;
						has2_q <= 1'b0;
						conv_q <= 1'b1;
					end
					REQ_E2M: begin
						op_q   <= OP_E2M;
						op2_q  <= OP_E2T;
						has2_q <= 1'b0;
						conv_q <= 1'b1;
					end
					REQ_T2M: begin
						op_q   <= OP_T2E;
						op2_q  <= OP_E2M;
						has2_q <= 1'b1;
						conv_q <= 1'b1;
					end
					default: begin
						op_q   <= OP_NEWTON;
						op2_q  <= OP_E2T;
						has2_q <= 1'b0;
						conv_q <= 1'b0;
					end
				endcase
			end
			S_ESQ: prod_q <= prod_d;
			S_SQINIT: begin
				sq_v_q   <= (63'd1 << 62) - prod_q[62:0];
				sq_res_q <= '0;
				sq_bit_q <= 63'd1 << 62;
			end
			S_SQRT: begin
				if (sq_take) begin
					sq_v_q <= sq_v_q - sq_trial[62:0];
				end
				sq_res_q <= sq_res_d;
				sq_bit_q <= sq_bit_q >> 2;
				root_q   <= sq_res_d[31:0];
			end
			S_SC_WAIT: begin
				s_q <= c_sin;
				c_q <= c_cos;
			end
			S_MUL_S: prod_q <= prod_d;
			S_MUL_C: begin
				f_q    <= f_d[33:0];
				prod_q <= prod_d;
			end
			S_DIV_WAIT: est_q <= sat_d;
			S_NEWT_CHK: begin
				if (step_mag < (ANGLE_W+1)'(tol_q)) begin
					conv_q <= 1'b1;
				end else if (n_q > lim_eff) begin
					conv_q <= 1'b0;
				end else begin
					ea_q <= est_q;
					n_q  <= n_q + 7'd1;
				end
			end
			default: ;
		endcase
		if (op_done) begin
			if (has2_q) begin
				ang_q  <= op_res;
				op_q   <= op2_q;
				has2_q <= 1'b0;
			end else begin
				res_q <= op_res;
			end
		end
	end

	// --- output register --------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || m_axis_tready)) begin
			out_angle_q <= res_q;
			out_iter_q  <= n_q;
			out_conv_q  <= conv_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_iter_q, out_angle_q};
	assign m_axis_tuser  = out_conv_q;

	// --- assertions -------------------------------------------------------
	a_cordic_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		c_done |-> (state_q == S_SC_WAIT || state_q == S_ATAN_WAIT))
		else $error("CORDIC finished outside a waiting state");

	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		d_done |-> state_q == S_DIV_WAIT)
		else $error("divider finished outside its waiting state");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_NEWT_CHK |-> n_q <= MAX_LIMIT + 7'd1)
		else $error("Newton step count beyond the limit");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> state_q != S_IDLE)
		else $error("request accepted but sequencer stayed idle");

endmodule
